// ===== sv/s16fr_pkg.sv =====
package s16fr_pkg;

  // frame layout
  localparam logic [7:0]  HEAD_FIRST        = 8'hEF;
  localparam logic [7:0]  HEAD_SECOND       = 8'h01;
  localparam logic [16:0] HEADER_BYTES      = 17'd9;
  localparam logic [16:0] MIN_HANDLED_BYTES = 17'd12;

  // default receive buffer size in bytes
  localparam int MAX_FRAME_BYTES_DEF = 128;

  // one result beat
  typedef struct packed {
    logic       byte_kept;
    logic [6:0] byte_pos;
    logic       frame_done;
    logic       checksum_bad;
    logic [7:0] resp_code;
    logic [7:0] package_kind;
    logic [6:0] data_len;
  } res_t;

endpackage

// ===== sv/s16fr_ifs.sv =====
// received byte channel
interface s16fr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// parser result channel
interface s16fr_res_if;
  logic       valid;
  logic       ready;
  logic       byte_kept;
  logic [6:0] byte_pos;
  logic       frame_done;
  logic       checksum_bad;
  logic [7:0] resp_code;
  logic [7:0] package_kind;
  logic [6:0] data_len;

  modport source (
    output valid, output byte_kept, output byte_pos, output frame_done,
    output checksum_bad, output resp_code, output package_kind, output data_len,
    input ready
  );
  modport sink (
    input valid, input byte_kept, input byte_pos, input frame_done,
    input checksum_bad, input resp_code, input package_kind, input data_len,
    output ready
  );
endinterface

// ===== sv/s16fr_parser.sv =====
module s16fr_parser #(
  parameter int MAX_FRAME_BYTES = s16fr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  output s16fr_pkg::res_t   res
);
  import s16fr_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [16:0] MAX17 = 17'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HEADER,
    PH_DATA
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       prev0_r, prev0_nxt;
  logic [7:0]       prev1_r, prev1_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [7:0]       ack_r, ack_nxt;

  logic [16:0]      pos_ext;
  logic [CNT_W-1:0] cnt_inc;
  logic [16:0]      cnt_inc_ext;
  logic [15:0]      sum_k;
  logic [15:0]      len_k;
  logic             full;
  logic             keep;
  logic             restart;
  logic             good;

  // values as they stand once this byte is stored
  assign pos_ext     = 17'(count_r);
  assign cnt_inc     = count_r + CNT_W'(1);
  assign cnt_inc_ext = 17'(cnt_inc);
  assign full        = pos_ext >= MAX17;
  assign sum_k       = (pos_ext >= 17'd8) ? sum_r + 16'(prev0_r) : sum_r;
  assign len_k       = (pos_ext == 17'd7) ? {rx_byte, len_r[7:0]} :
                       (pos_ext == 17'd8) ? {len_r[15:8], rx_byte} : len_r;
  assign good        = (prev1_r == sum_k[15:8]) && (rx_byte == sum_k[7:0]);

  // per-byte parser step
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    prev0_nxt = prev0_r;
    prev1_nxt = prev1_r;
    kind_nxt  = kind_r;
    ack_nxt   = ack_r;
    res       = '0;
    keep      = 1'b0;
    restart   = 1'b0;

    unique case (phase_r)
      PH_HUNT1: begin
        if (rx_byte == HEAD_FIRST) begin
          keep      = 1'b1;
          phase_nxt = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (rx_byte == HEAD_SECOND) begin
          keep      = 1'b1;
          phase_nxt = PH_HEADER;
        end else begin
          restart = 1'b1;
        end
      end
      PH_HEADER: begin
        if (full) begin
          restart = 1'b1;
        end else begin
          keep = 1'b1;
          if (cnt_inc_ext >= HEADER_BYTES) begin
            if (17'(len_k) + HEADER_BYTES > MAX17) begin
              restart = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (full) begin
          restart = 1'b1;
        end else begin
          keep = 1'b1;
          // frame ends here: check the sum against the last two bytes
          if (cnt_inc_ext >= 17'(len_r) + HEADER_BYTES) begin
            if (!good) begin
              res.checksum_bad = 1'b1;
            end else if (cnt_inc_ext >= MIN_HANDLED_BYTES) begin
              res.frame_done   = 1'b1;
              res.resp_code    = ack_r;
              res.package_kind = kind_r;
              res.data_len     = 7'(len_r - 16'd2);
            end
            restart = 1'b1;
          end
        end
      end
      default: restart = 1'b1;
    endcase

    // store the byte and advance the sum delay line
    if (keep) begin
      count_nxt     = cnt_inc;
      sum_nxt       = sum_k;
      len_nxt       = len_k;
      prev0_nxt     = prev1_r;
      prev1_nxt     = rx_byte;
      res.byte_kept = 1'b1;
      res.byte_pos  = pos_ext[6:0];
      if (pos_ext == 17'd6) begin
        kind_nxt = rx_byte;
      end
      if (pos_ext == 17'd9) begin
        ack_nxt = rx_byte;
      end
      if (cnt_inc_ext >= MAX17) begin
        restart = 1'b1;
      end
    end

    if (restart) begin
      phase_nxt = PH_HUNT1;
      count_nxt = '0;
      len_nxt   = '0;
      sum_nxt   = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      count_r <= '0;
      len_r   <= '0;
      sum_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
    end
    if (step_en) begin
      prev0_r <= prev0_nxt;
      prev1_r <= prev1_nxt;
      kind_r  <= kind_nxt;
      ack_r   <= ack_nxt;
    end
  end

endmodule

// ===== sv/sum16_frame_receiver_top.sv =====
// Byte-serial receiver for frames of the form EF 01, four address bytes,
// a package kind byte, a big-endian length and data closed by a 16-bit
// sum. Each accepted rx_byte beat yields exactly one result beat telling
// whether the byte was stored, its position in the frame, and at the last
// byte of a frame either frame_done (with response code, package kind and
// data length, for frames of at least 12 bytes) or checksum_bad. One byte
// is taken every clock cycle while the result side does not stall; a byte
// sits in the input register while the parser step runs, and the step
// then lands in the result register. Back-pressure
// on the result side stalls the input only once both registers are full.
// There is no clearing pass after reset.
module sum16_frame_receiver_top #(
  parameter int MAX_FRAME_BYTES = s16fr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  s16fr_rx_if.sink     in_if,
  s16fr_res_if.source  out_if
);
  import s16fr_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  res_t       out_res_r;
  res_t       step_res;
  logic       advance;

  // a byte moves through the parser when the result register can take it
  assign advance     = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.rx_byte;
    end
  end

  s16fr_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_byte_r),
    .res     (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.byte_kept    = out_res_r.byte_kept;
  assign out_if.byte_pos     = out_res_r.byte_pos;
  assign out_if.frame_done   = out_res_r.frame_done;
  assign out_if.checksum_bad = out_res_r.checksum_bad;
  assign out_if.resp_code    = out_res_r.resp_code;
  assign out_if.package_kind = out_res_r.package_kind;
  assign out_if.data_len     = out_res_r.data_len;

  // a frame cannot end both good and bad
  a_done_xor_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_res_r.frame_done && out_res_r.checksum_bad))
    else $error("frame_done and checksum_bad together");

  // a frame end is always on a stored byte
  a_end_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_res_r.frame_done || out_res_r.checksum_bad)
      |-> out_res_r.byte_kept)
    else $error("frame end on a byte that was not stored");

  // a dropped byte reports no position or frame fields
  a_unkept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.byte_kept
      |-> (out_res_r.byte_pos == 7'd0) && (out_res_r.resp_code == 8'd0))
    else $error("unkept byte carries frame fields");

  // a byte waiting for the parser is held
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r))
    else $error("input register lost a waiting byte");

endmodule
